FILE: rtl/dct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct_pkg
// Shared constants, codes and types of the detection confirmation table.
// ----------------------------------------------------------------------------
package dct_pkg;

  localparam int DCT_MAX_ENTRIES = 32;
  localparam int DCT_MAX_TRACKED = 16;
  localparam int DCT_COORD_BITS  = 12;

  localparam int FIELD_BITS = 12;
  localparam int HITS_BITS  = 16;
  localparam int AGE_BITS   = 8;
  localparam int USED_BITS  = 6;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 16;

  localparam logic [HITS_BITS-1:0] HITS_MAX = '1;
  localparam logic [AGE_BITS-1:0]  AGE_MAX  = '1;

  localparam logic [15:0] HIT_THRESHOLD_RST = 16'd3;
  localparam logic [7:0]  AGE_LIMIT_RST     = 8'd5;

  typedef enum logic [1:0] {
    OP_LOAD_TRACKED = 2'd0,
    OP_DETECT       = 2'd1,
    OP_END_FRAME    = 2'd2,
    OP_UNUSED       = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    STAT_TRACKED_STORED = 3'd0,
    STAT_ALREADY_TRACKED = 3'd1,
    STAT_MATCHED        = 3'd2,
    STAT_NEW_ENTRY      = 3'd3,
    STAT_TABLE_FULL     = 3'd4,
    STAT_TRACKED_FULL   = 3'd5,
    STAT_FRAME_AGED     = 3'd6,
    STAT_RSVD           = 3'd7
  } status_t;

  typedef enum logic [0:0] {
    CFG_HIT_THRESHOLD = 1'b0,
    CFG_AGE_LIMIT     = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEXT,
    ST_RD,
    ST_SPAN,
    ST_MUL,
    ST_CMP,
    ST_AGE,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_TRK,
    PH_ENT,
    PH_AGE
  } phase_t;

endpackage

FILE: rtl/dct_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/dct_ovl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct_ovl
// Shared box overlap unit: spans, then products, then 4*inter > areaA+areaB.
// ----------------------------------------------------------------------------
module dct_ovl #(
  parameter int CB = 12
) (
  input  logic          clk,
  input  logic [4*CB-1:0] box_a,   // x, y, w, h from low bits up
  input  logic [4*CB-1:0] box_b,
  output logic          hit
);

  localparam int EW = CB + 1;

  logic [CB-1:0] ax, ay, aw, ah, bx, by, bw, bh;
  logic [EW-1:0] sx, sy;
  logic [EW-1:0] sx_r, sy_r;
  logic [CB-1:0] aw_r, ah_r, bw_r, bh_r;
  logic [2*EW-1:0] inter_r;
  logic [2*CB-1:0] area_a_r, area_b_r;

  assign {ah, aw, ay, ax} = box_a;
  assign {bh, bw, by, bx} = box_b;

  function automatic logic [EW-1:0] span(input logic [CB-1:0] a0, input logic [CB-1:0] al,
                                         input logic [CB-1:0] b0, input logic [CB-1:0] bl);
    logic [EW-1:0] lo, ae, be, hi;
    lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
    ae = {1'b0, a0} + {1'b0, al};
    be = {1'b0, b0} + {1'b0, bl};
    hi = (ae < be) ? ae : be;
    return (hi > lo) ? hi - lo : '0;
  endfunction

  assign sx = span(ax, aw, bx, bw);
  assign sy = span(ay, ah, by, bh);

  always_ff @(posedge clk) begin
    sx_r <= sx;
    sy_r <= sy;
    aw_r <= aw;
    ah_r <= ah;
    bw_r <= bw;
    bh_r <= bh;
    inter_r  <= sx_r * sy_r;
    area_a_r <= aw_r * ah_r;
    area_b_r <= bw_r * bh_r;
  end

  assign hit = ({inter_r, 2'b00} > ((2*EW+2)'(area_a_r) + (2*EW+2)'(area_b_r)));

endmodule

FILE: rtl/detection_confirmation_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_confirmation_table
// M-of-N confirmation of box detections across frames.
// ----------------------------------------------------------------------------
// Input words (in_*) carry an opcode and a box: load a tracked box, offer a
// detection, or end the frame. Each accepted word gives exactly one output
// word (out_*) with status, to_track and the count of candidate entries.
// Registers are written through cfg_we/cfg_index/cfg_wdata; the user must do
// so only while idle, as the block does not enforce it. One word is worked
// on at a time; in_tready is high only when idle. Load and unused opcodes go
// from ST_NEXT straight to ST_DONE. A detection scans the tracked list, then
// the candidate table, one stored box at a time through the shared overlap
// unit (issue, RAM read, span stage, multiply stage, compare), stopping at
// the first overlap. End of frame walks the table one entry at a time
// (issue, RAM read, age), compacting in place. A finished word waits in the
// output register while out_tready is low; the next input word is taken
// once that register has been loaded. Reset empties both lists and loads
// the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module detection_confirmation_table
  import dct_pkg::*;
#(
  parameter int MAX_ENTRIES = DCT_MAX_ENTRIES,
  parameter int MAX_TRACKED = DCT_MAX_TRACKED,
  parameter int COORD_BITS  = DCT_COORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // opcode[1:0], box_x[13:2], box_y[25:14], box_w[37:26], box_h[49:38]
  input  logic [dct_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // status[2:0], to_track[3], entries_in_use[9:4]
  output logic [dct_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [15:0]                   cfg_wdata
);

  localparam int CB   = COORD_BITS;
  localparam int BW   = 4 * CB;
  localparam int EAW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int TAW  = (MAX_TRACKED > 1) ? $clog2(MAX_TRACKED) : 1;
  localparam int ECW  = $clog2(MAX_ENTRIES + 1);
  localparam int TCW  = $clog2(MAX_TRACKED + 1);
  localparam int IW   = (ECW > TCW) ? ECW : TCW;
  localparam int EWD  = BW + HITS_BITS + AGE_BITS;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic [15:0]        thr_r;
  logic [7:0]         age_lim_r;
  opcode_t            op_r, op_nxt;
  logic [BW-1:0]      box_r, box_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic [ECW-1:0]     widx_r, widx_nxt;
  logic [ECW-1:0]     ent_total_r, ent_total_nxt;
  logic [TCW-1:0]     trk_total_r, trk_total_nxt;
  status_t            status_r, status_nxt;
  logic               flag_r, flag_nxt;
  logic               out_valid_r;
  status_t            out_status_r;
  logic               out_flag_r;
  logic [USED_BITS-1:0] out_used_r;

  logic               e_we, t_we;
  logic [EAW-1:0]     e_waddr;
  logic [EWD-1:0]     e_wdata, e_rdata;
  logic [TAW-1:0]     t_waddr;
  logic [BW-1:0]      t_rdata, ovl_b;
  logic               ovl_hit;
  logic               in_acc;

  logic [BW-1:0]        e_box;
  logic [HITS_BITS-1:0] e_hits, hits_inc;
  logic [AGE_BITS-1:0]  e_age, age_inc;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign {e_age, e_hits, e_box} = e_rdata;
  assign hits_inc = (e_hits == HITS_MAX) ? e_hits : e_hits + 1'b1;
  assign age_inc  = (e_age == AGE_MAX) ? e_age : e_age + 1'b1;
  assign ovl_b    = (phase_r == PH_TRK) ? t_rdata : e_box;

  dct_ram #(.WIDTH(EWD), .DEPTH(MAX_ENTRIES), .AW(EAW)) u_entry_ram (
    .clk, .wr_en(e_we), .wr_addr(e_waddr), .wr_data(e_wdata),
    .rd_addr(idx_r[EAW-1:0]), .rd_data(e_rdata)
  );

  dct_ram #(.WIDTH(BW), .DEPTH(MAX_TRACKED), .AW(TAW)) u_trk_ram (
    .clk, .wr_en(t_we), .wr_addr(t_waddr), .wr_data(box_r),
    .rd_addr(idx_r[TAW-1:0]), .rd_data(t_rdata)
  );

  dct_ovl #(.CB(CB)) u_ovl (
    .clk, .box_a(box_r), .box_b(ovl_b), .hit(ovl_hit)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_NEXT;
      ST_NEXT: begin
        unique case (op_r)
          OP_DETECT: begin
            if (phase_r == PH_TRK) begin
              if (IW'(idx_r) < IW'(trk_total_r)) state_nxt = ST_RD;
            end else if (IW'(idx_r) < IW'(ent_total_r)) begin
              state_nxt = ST_RD;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          OP_END_FRAME: state_nxt = (IW'(idx_r) < IW'(ent_total_r)) ? ST_RD : ST_DONE;
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_RD:   state_nxt = (phase_r == PH_AGE) ? ST_AGE : ST_SPAN;
      ST_SPAN: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ovl_hit ? ST_DONE : ST_NEXT;
      ST_AGE:  state_nxt = ST_NEXT;
      ST_DONE: if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and RAM writes
  always_comb begin
    phase_nxt     = phase_r;
    op_nxt        = op_r;
    box_nxt       = box_r;
    idx_nxt       = idx_r;
    widx_nxt      = widx_r;
    ent_total_nxt = ent_total_r;
    trk_total_nxt = trk_total_r;
    status_nxt    = status_r;
    flag_nxt      = flag_r;
    e_we          = 1'b0;
    e_waddr       = idx_r[EAW-1:0];
    e_wdata       = {age_inc, hits_inc, box_r};
    t_we          = 1'b0;
    t_waddr       = trk_total_r[TAW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt   = opcode_t'(in_tdata[1:0]);
          box_nxt  = {CB'(in_tdata[49:38]), CB'(in_tdata[37:26]),
                      CB'(in_tdata[25:14]), CB'(in_tdata[13:2])};
          idx_nxt  = '0;
          widx_nxt = '0;
          flag_nxt = 1'b0;
          phase_nxt = (opcode_t'(in_tdata[1:0]) == OP_END_FRAME) ? PH_AGE : PH_TRK;
        end
      end
      ST_NEXT: begin
        unique case (op_r)
          OP_LOAD_TRACKED: begin
            if (trk_total_r == TCW'(MAX_TRACKED)) begin
              status_nxt = STAT_TRACKED_FULL;
            end else begin
              t_we          = 1'b1;
              trk_total_nxt = trk_total_r + 1'b1;
              status_nxt    = STAT_TRACKED_STORED;
            end
          end
          OP_DETECT: begin
            if (phase_r == PH_TRK) begin
              if (!(IW'(idx_r) < IW'(trk_total_r))) begin
                phase_nxt = PH_ENT;
                idx_nxt   = '0;
              end
            end else if (!(IW'(idx_r) < IW'(ent_total_r))) begin
              if (ent_total_r == ECW'(MAX_ENTRIES)) begin
                status_nxt = STAT_TABLE_FULL;
              end else begin
                e_we          = 1'b1;
                e_waddr       = ent_total_r[EAW-1:0];
                e_wdata       = {AGE_BITS'(1), HITS_BITS'(1), box_r};
                ent_total_nxt = ent_total_r + 1'b1;
                status_nxt    = STAT_NEW_ENTRY;
              end
            end
          end
          OP_END_FRAME: begin
            trk_total_nxt = '0;
            if (!(IW'(idx_r) < IW'(ent_total_r))) begin
              ent_total_nxt = widx_r;
              status_nxt    = STAT_FRAME_AGED;
            end
          end
          default: status_nxt = STAT_TRACKED_STORED;
        endcase
      end
      ST_CMP: begin
        if (ovl_hit) begin
          if (phase_r == PH_TRK) begin
            status_nxt = STAT_ALREADY_TRACKED;
          end else begin
            e_we       = 1'b1;
            e_wdata    = {e_age, hits_inc, box_r};
            flag_nxt   = (hits_inc >= thr_r);
            status_nxt = STAT_MATCHED;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_AGE: begin
        // kept entries slide down to the write pointer
        e_waddr = widx_r[EAW-1:0];
        e_wdata = {age_inc, e_hits, e_box};
        if (age_inc > age_lim_r) begin
          e_wdata = {age_inc, e_hits - 1'b1, e_box};
          e_we    = (e_hits > HITS_BITS'(1));
        end else begin
          e_we = 1'b1;
        end
        if (e_we) widx_nxt = widx_r + 1'b1;
        idx_nxt = idx_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_TRK;
      ent_total_r <= '0;
      trk_total_r <= '0;
      out_valid_r <= 1'b0;
      thr_r       <= HIT_THRESHOLD_RST;
      age_lim_r   <= AGE_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      ent_total_r <= ent_total_nxt;
      trk_total_r <= trk_total_nxt;
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_HIT_THRESHOLD: thr_r     <= cfg_wdata;
          default:           age_lim_r <= cfg_wdata[7:0];
        endcase
      end
      if (state_r == ST_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    box_r    <= box_nxt;
    idx_r    <= idx_nxt;
    widx_r   <= widx_nxt;
    status_r <= status_nxt;
    flag_r   <= flag_nxt;
    if (state_r == ST_DONE && (!out_valid_r || out_tready)) begin
      out_status_r <= status_r;
      out_flag_r   <= flag_r;
      out_used_r   <= USED_BITS'(ent_total_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_used_r, out_flag_r, out_status_r};

`ifndef ASSERT_OFF
  a_ent_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ent_total_r <= ECW'(MAX_ENTRIES)) else $error("entry count overflow");
  a_trk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    trk_total_r <= TCW'(MAX_TRACKED)) else $error("tracked count overflow");
  a_flag_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_flag_r) |-> (out_status_r == STAT_MATCHED))
    else $error("to_track without match");
  a_busy_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready) else $error("ready while busy");
`endif

endmodule
